FILE: design/kdlp_pkg.sv
// kdlp_pkg: shared constants and types for the key debounce / long-press unit
// depends on nothing; imported by every module of the block

package kdlp_pkg;

   // number of keys scanned per tick
   localparam int NUM_KEYS = 3;

   // tick counter and config register width
   localparam int CNT_W = 16;

   // config port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RESET   = 16'd2;
   localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RESET = 16'd100;

   // per-key phase codes
   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DOWN = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;
   localparam logic [PHASE_W-1:0] PH_UP   = 2'd3;

   // events one key raises in one tick
   typedef struct packed {
      logic pressed;
      logic long_press;
      logic released;
   } kdlp_event_type;

   // one result item
   typedef struct packed {
      logic [NUM_KEYS-1:0] pressed_mask;
      logic [NUM_KEYS-1:0] long_press_mask;
      logic [NUM_KEYS-1:0] released_mask;
   } kdlp_result_type;

endpackage

FILE: design/kdlp_key_fsm.sv
// kdlp_key_fsm: phase machine and tick counter of one key
// depends on kdlp_pkg; instanced once per key by key_debounce_long_press_unit

module kdlp_key_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        level,
   input  logic [kdlp_pkg::CNT_W-1:0]  debounce_ticks,
   input  logic [kdlp_pkg::CNT_W-1:0]  long_press_ticks,
   output kdlp_pkg::kdlp_event_type    events
);
   import kdlp_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [CNT_W-1:0]   ticks_ff;
   logic [CNT_W-1:0]   ticks_in;
   logic [CNT_W-1:0]   hold_base;
   logic [CNT_W-1:0]   hold_inc;
   logic [CNT_W-1:0]   ticks_inc;

   // counter increments, wrapping modulo 2^16
   assign ticks_inc = ticks_ff + 1'b1;
   // in hold, a release first clears the counter, then it increments
   assign hold_base = level ? '0 : ticks_ff;
   assign hold_inc  = hold_base + 1'b1;

   // next phase, counter and events for this tick
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      events   = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!level) begin
               phase_in = PH_DOWN;
               ticks_in = '0;
            end
         end
         PH_DOWN: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= debounce_ticks) begin
               if (!level) begin
                  phase_in       = PH_HOLD;
                  ticks_in       = '0;
                  events.pressed = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_HOLD: begin
            if (level) begin
               phase_in = PH_UP;
            end
            ticks_in = hold_inc;
            if (hold_inc >= long_press_ticks) begin
               events.long_press = 1'b1;
               ticks_in          = '0;
            end
         end
         PH_UP: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= debounce_ticks) begin
               if (level) begin
                  events.released = 1'b1;
                  phase_in        = PH_IDLE;
               end else begin
                  phase_in = PH_HOLD;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // state advances only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

FILE: design/key_debounce_long_press_unit.sv
// key_debounce_long_press_unit: top level, key debounce and long-press detection
// depends on kdlp_pkg and kdlp_key_fsm
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_key_levels
//   rsp      out        rsp_valid/rsp_stall  rsp_pressed_mask, rsp_long_press_mask,
//                                            rsp_released_mask
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one tick per clock while req_stall is low; each result is registered
// per-key state and the result are computed in the cycle of acceptance, limited
// by one 16-bit increment and compare per key
// a two-entry output buffer (result register plus skid) keeps req_stall registered
// req_stall rises only when both output entries hold untaken results
// reset clears all keys to idle, the counters to zero and the registers to 2 / 100

module key_debounce_long_press_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kdlp_pkg::NUM_KEYS-1:0]     req_key_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_pressed_mask,
   output logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_long_press_mask,
   output logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_released_mask,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdlp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kdlp_pkg::CNT_W-1:0]        csr_wdata
);
   import kdlp_pkg::*;

   logic [CNT_W-1:0]  debounce_ticks_ff;
   logic [CNT_W-1:0]  long_press_ticks_ff;
   logic              accept;
   logic              drain;
   kdlp_event_type    key_events [NUM_KEYS];
   kdlp_result_type   result;
   kdlp_result_type   out_data_ff;
   kdlp_result_type   skid_data_ff;
   logic              out_valid_ff;
   logic              skid_valid_ff;

   // config registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= DEBOUNCE_TICKS_RESET;
         long_press_ticks_ff <= LONG_PRESS_TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEBOUNCE_TICKS) begin
            debounce_ticks_ff <= csr_wdata;
         end else if (csr_index == CSR_LONG_PRESS_TICKS) begin
            long_press_ticks_ff <= csr_wdata;
         end
      end
   end

   // handshake
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign drain     = out_valid_ff & ~rsp_stall;

   // one phase machine per key
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      kdlp_key_fsm u_key (
         .clock            (clock),
         .reset            (reset),
         .step             (accept),
         .level            (req_key_levels[k]),
         .debounce_ticks   (debounce_ticks_ff),
         .long_press_ticks (long_press_ticks_ff),
         .events           (key_events[k])
      );
   end

   // gather per-key events into masks
   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         result.pressed_mask[k]    = key_events[k].pressed;
         result.long_press_mask[k] = key_events[k].long_press;
         result.released_mask[k]   = key_events[k].released;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (drain) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (drain) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (drain) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pressed_mask    = out_data_ff.pressed_mask;
   assign rsp_long_press_mask = out_data_ff.long_press_mask;
   assign rsp_released_mask   = out_data_ff.released_mask;

endmodule

FILE: design/kdlp_checker.sv
// kdlp_checker: port-level assertions for key_debounce_long_press_unit
// depends on kdlp_pkg; bound to the top level at the end of this file

module kdlp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_pressed_mask,
   input  logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_long_press_mask,
   input  logic [kdlp_pkg::NUM_KEYS-1:0]     rsp_released_mask
);
   import kdlp_pkg::*;

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input stalls only while the output register holds a result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // a key cannot confirm press and release in the same tick
   a_press_release_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pressed_mask & rsp_released_mask) == '0))
      else $error("press and release on same key");

   // a press confirmation and a long press come from different phases
   a_press_long_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pressed_mask & rsp_long_press_mask) == '0))
      else $error("press and long press on same key");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressed_mask)
         && $stable(rsp_long_press_mask) && $stable(rsp_released_mask))
      else $error("stalled result changed");

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_pressed_mask    (rsp_pressed_mask),
   .rsp_long_press_mask (rsp_long_press_mask),
   .rsp_released_mask   (rsp_released_mask)
);
